FILE: src/mandel_pkg.sv
// Shared constants, types and state codes for the escape-time pixel block.
// No dependencies; every other file imports this package.
package mandel_pkg;

    // Fixed-point format of c and z: FRAC_BITS fraction bits (Q4.28)
    localparam int FRAC_BITS      = 28;
    localparam int IMAGE_SIZE_DEF = 512;

    // Field widths
    localparam int IDX_W    = 9;
    localparam int CENTER_W = 32;
    localparam int ZOOM_W   = 5;
    localparam int GREY_W   = 8;

    // z and c components, bounded below 8 in magnitude
    localparam int ZW = FRAC_BITS + 4;
    // multiplier operand: |z| < 2 fits this signed width
    localparam int MW = FRAC_BITS + 2;
    // exact product width
    localparam int PW = 2 * MW;

    localparam int MAX_ITER = 255;

    // c saturation bound, just under 4
    localparam longint C_CAP  = (longint'(1) << (FRAC_BITS + 2)) - 1;
    // 2.0 with FRAC_BITS fraction bits
    localparam longint C_TWO  = longint'(1) << (FRAC_BITS + 1);
    // 4.0 with 2*FRAC_BITS fraction bits
    localparam longint C_FOUR = longint'(1) << (2 * FRAC_BITS + 2);

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [1:0] REG_CENTER_RE = 2'd0;
    localparam logic [1:0] REG_CENTER_IM = 2'd1;
    localparam logic [1:0] REG_ZOOM      = 2'd2;
    localparam logic [ZOOM_W-1:0] ZOOM_RESET = 5'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COORD,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    // Sequencer to datapath
    typedef struct packed {
        logic load_pix;
        logic load_c;
        logic mul_en;
        logic upd_en;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic              big;
        logic              escape;
        logic              last;
        logic [GREY_W-1:0] iter_n;
    } stat_t;

endpackage

FILE: src/mandel_ifs.sv
// Valid/ready channel interfaces for pixel requests and grey-level results.
// Depends on mandel_pkg for field widths.
interface mandel_pix_if;
    import mandel_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] pixel_row;
    logic [IDX_W-1:0] pixel_col;
    modport source (output valid, output pixel_row, output pixel_col, input ready);
    modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

interface mandel_grey_if;
    import mandel_pkg::*;
    logic              valid;
    logic              ready;
    logic [GREY_W-1:0] grey_level;
    modport source (output valid, output grey_level, input ready);
    modport sink   (input valid, input grey_level, output ready);
endinterface

FILE: src/mandel_cfg.sv
// APB-style configuration registers: image center and zoom shift.
// Depends on mandel_pkg.
module mandel_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mandel_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [mandel_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [mandel_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                 pready,
    output logic signed [mandel_pkg::CENTER_W-1:0] center_re,
    output logic signed [mandel_pkg::CENTER_W-1:0] center_im,
    output logic [mandel_pkg::ZOOM_W-1:0]        zoom_shift
);
    import mandel_pkg::*;

    logic signed [CENTER_W-1:0] center_re_reg;
    logic signed [CENTER_W-1:0] center_im_reg;
    logic [ZOOM_W-1:0]          zoom_reg;
    logic                       wr_en;
    logic [1:0]                 reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_re_reg <= '0;
            center_im_reg <= '0;
            zoom_reg      <= ZOOM_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_CENTER_RE: center_re_reg <= $signed(pwdata[CENTER_W-1:0]);
                REG_CENTER_IM: center_im_reg <= $signed(pwdata[CENTER_W-1:0]);
                REG_ZOOM:      zoom_reg      <= pwdata[ZOOM_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_sel)
            REG_CENTER_RE: prdata = CFG_DATA_W'(unsigned'(center_re_reg));
            REG_CENTER_IM: prdata = CFG_DATA_W'(unsigned'(center_im_reg));
            REG_ZOOM:      prdata = CFG_DATA_W'(zoom_reg);
            default:       prdata = '0;
        endcase
    end

    assign center_re  = center_re_reg;
    assign center_im  = center_im_reg;
    assign zoom_shift = zoom_reg;

endmodule

FILE: src/mandel_coord.sv
// Maps a pixel index to one component of c: center + (index - SIZE/2) * 2^-zoom,
// floor-rounded on right shifts and saturated just under 4. Depends on mandel_pkg.
module mandel_coord #(
    parameter int IMAGE_SIZE = mandel_pkg::IMAGE_SIZE_DEF
) (
    input  logic signed [mandel_pkg::CENTER_W-1:0] center,
    input  logic [mandel_pkg::IDX_W-1:0]           index,
    input  logic [mandel_pkg::ZOOM_W-1:0]          zoom,
    output logic signed [mandel_pkg::ZW-1:0]       coord
);
    import mandel_pkg::*;

    localparam int HALF     = IMAGE_SIZE / 2;
    localparam int LOG_SIZE = $clog2(IMAGE_SIZE);
    // signed offset width covers both -HALF and the largest index minus HALF
    localparam int DW = ((IDX_W > LOG_SIZE) ? IDX_W : LOG_SIZE) + 1;
    localparam int OW = DW + FRAC_BITS;
    localparam int SW = ((OW > CENTER_W) ? OW : CENTER_W) + 2;
    localparam logic signed [DW-1:0] HALF_D = DW'(HALF);
    localparam logic signed [SW-1:0] CAP_S  = SW'(C_CAP);
    localparam logic [ZOOM_W-1:0]    FRAC_Z = ZOOM_W'(FRAC_BITS);

    logic signed [DW-1:0] d;
    logic                 neg;
    logic [DW-1:0]        ad;
    logic [ZOOM_W-1:0]    k;
    logic [ZOOM_W-1:0]    sh;
    logic                 rem;
    logic [OW-1:0]        off;
    logic signed [SW-1:0] sum;

    // Offset magnitude; the left shift never reaches the 2^62 limit at these widths
    always_comb
    begin
        d   = $signed({{(DW-IDX_W){1'b0}}, index}) - HALF_D;
        neg = d[DW-1];
        ad  = neg ? DW'(-d) : DW'(d);
        sh  = FRAC_Z - zoom;
        k   = zoom - FRAC_Z;
        rem = (ad & ~({DW{1'b1}} << k)) != '0;
        if (zoom <= FRAC_Z)
        begin
            off = OW'(ad) << sh;
        end
        else
        begin
            off = OW'(ad >> k) + OW'(neg && rem);
        end
    end

    // Add to center and clamp
    always_comb
    begin
        if (neg)
        begin
            sum = $signed(SW'(center)) - $signed(SW'(off));
        end
        else
        begin
            sum = $signed(SW'(center)) + $signed(SW'(off));
        end
        if (sum > CAP_S)
        begin
            coord = ZW'(CAP_S);
        end
        else if (sum < -CAP_S)
        begin
            coord = ZW'(-CAP_S);
        end
        else
        begin
            coord = ZW'(sum);
        end
    end

endmodule

FILE: src/mandel_iter.sv
// Iteration datapath: pixel and c registers, the z registers, the squaring and
// product multipliers and the escape test. Depends on mandel_pkg, mandel_coord.
module mandel_iter #(
    parameter int IMAGE_SIZE = mandel_pkg::IMAGE_SIZE_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mandel_pkg::ctrl_t                      ctrl,
    input  logic [mandel_pkg::IDX_W-1:0]           pixel_row,
    input  logic [mandel_pkg::IDX_W-1:0]           pixel_col,
    input  logic signed [mandel_pkg::CENTER_W-1:0] center_re,
    input  logic signed [mandel_pkg::CENTER_W-1:0] center_im,
    input  logic [mandel_pkg::ZOOM_W-1:0]          zoom_shift,
    output mandel_pkg::stat_t                      stat
);
    import mandel_pkg::*;

    localparam logic signed [ZW-1:0] TWO_Z  = ZW'(C_TWO);
    localparam logic [PW:0]          FOUR_W = (PW+1)'(C_FOUR);
    localparam logic [GREY_W-1:0]    LAST_N = GREY_W'(MAX_ITER - 1);

    logic [IDX_W-1:0]     row_reg;
    logic [IDX_W-1:0]     col_reg;
    logic signed [ZW-1:0] cr_reg;
    logic signed [ZW-1:0] ci_reg;
    logic signed [ZW-1:0] zr_reg;
    logic signed [ZW-1:0] zi_reg;
    logic signed [PW-1:0] sr_reg;
    logic signed [PW-1:0] si_reg;
    logic signed [PW-1:0] pz_reg;
    logic [GREY_W-1:0]    n_reg;

    logic signed [ZW-1:0] cr_w;
    logic signed [ZW-1:0] ci_w;
    logic signed [MW-1:0] zr_op;
    logic signed [MW-1:0] zi_op;
    logic [PW:0]          sum_sq;
    logic signed [PW:0]   diff_w;
    logic signed [PW:0]   re_w;
    logic signed [PW:0]   im_w;
    logic signed [ZW-1:0] zr_next;
    logic signed [ZW-1:0] zi_next;

    mandel_coord #(.IMAGE_SIZE(IMAGE_SIZE)) u_coord_re (
        .center (center_re),
        .index  (col_reg),
        .zoom   (zoom_shift),
        .coord  (cr_w)
    );

    mandel_coord #(.IMAGE_SIZE(IMAGE_SIZE)) u_coord_im (
        .center (center_im),
        .index  (row_reg),
        .zoom   (zoom_shift),
        .coord  (ci_w)
    );

    // Multiplier operands; only used once each z component is known to be under 2
    assign zr_op = zr_reg[MW-1:0];
    assign zi_op = zi_reg[MW-1:0];

    // Escape test and next z, both from the registered products
    always_comb
    begin
        sum_sq  = (PW+1)'(unsigned'(sr_reg)) + (PW+1)'(unsigned'(si_reg));
        diff_w  = (PW+1)'(sr_reg) - (PW+1)'(si_reg);
        re_w    = diff_w >>> FRAC_BITS;
        // 2*zr*zi brought to FRAC_BITS: one less bit of shift
        im_w    = (PW+1)'(pz_reg) >>> (FRAC_BITS - 1);
        zr_next = ZW'(re_w) + cr_reg;
        zi_next = ZW'(im_w) + ci_reg;
    end

    // Pixel, c and products: payload only
    always_ff @(posedge clk)
    begin
        if (ctrl.load_pix)
        begin
            row_reg <= pixel_row;
            col_reg <= pixel_col;
        end
        if (ctrl.load_c)
        begin
            cr_reg <= cr_w;
            ci_reg <= ci_w;
        end
        if (ctrl.mul_en)
        begin
            sr_reg <= zr_op * zr_op;
            si_reg <= zi_op * zi_op;
            pz_reg <= zr_op * zi_op;
        end
    end

    // z starts at zero with c; advances once per iteration
    always_ff @(posedge clk)
    begin
        if (ctrl.load_c)
        begin
            zr_reg <= '0;
            zi_reg <= '0;
        end
        else if (ctrl.upd_en)
        begin
            zr_reg <= zr_next;
            zi_reg <= zi_next;
        end
    end

    // Iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
        end
        else if (ctrl.load_c)
        begin
            n_reg <= '0;
        end
        else if (ctrl.upd_en)
        begin
            n_reg <= n_reg + 1'b1;
        end
    end

    assign stat.big    = (zr_reg >= TWO_Z) || (zr_reg <= -TWO_Z)
                      || (zi_reg >= TWO_Z) || (zi_reg <= -TWO_Z);
    assign stat.escape = sum_sq >= FOUR_W;
    assign stat.last   = n_reg == LAST_N;
    assign stat.iter_n = n_reg;

endmodule

FILE: src/mandel_seq.sv
// Sequencer for one pixel at a time, plus the result register toward the sink.
// Depends on mandel_pkg.
module mandel_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mandel_pkg::GREY_W-1:0]     grey_level,
    output mandel_pkg::ctrl_t                 ctrl,
    input  mandel_pkg::stat_t                 stat
);
    import mandel_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [GREY_W-1:0] grey_reg;
    logic              out_load;

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            grey_reg <= GREY_W'(MAX_ITER) - stat.iter_n;
        end
    end

    // Next state and controls
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load_pix = 1'b1;
                    state_next    = ST_COORD;
                end
            end
            ST_COORD:
            begin
                ctrl.load_c = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                if (stat.big)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctrl.mul_en = 1'b1;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (stat.escape)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctrl.upd_en = 1'b1;
                    state_next  = stat.last ? ST_DONE : ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign grey_level = grey_reg;

`ifndef SYNTHESIS
    a_acc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACC |-> $past(state_reg) == ST_MUL)
        else $error("accumulate step without a preceding multiply step");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_COORD)
        else $error("accepted request did not start coordinate setup");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_valid_reg && !out_ready |=> state_reg == ST_DONE)
        else $error("finished pixel left while result register was full");
`endif

endmodule

FILE: src/mandelbrot_escape_time_pixel_top.sv
// Top level of the escape-time pixel block: config registers, sequencer, datapath.
// Depends on mandel_pkg, mandel_ifs, mandel_cfg, mandel_iter, mandel_seq.
//
// Usage:
//   pixel (valid/ready) carries one request: pixel_row and pixel_col. The block
//   maps it to c = center + (col - SIZE/2, row - SIZE/2) * 2^-zoom_shift and
//   iterates z = z^2 + c until |z|^2 >= 4 or 255 iterations.
//   grey (valid/ready) returns grey_level = 255 - iteration count.
//   One pixel is in flight at a time. After an accepted request: coordinate
//   setup, then per iteration a multiply step and an escape test and z update
//   step (three product multipliers working in parallel), then the load of the
//   result register. A pixel ends on the escape test, on the iteration limit or
//   in the multiply step when a z component is already 2 or more, which skips
//   the multiply. The next request can be taken in the cycle after the result
//   loads.
//   The result register frees the core: the next request is taken while a
//   result still waits. If the sink stalls with a result pending, the next
//   finished pixel holds in the core until the register is free.
//   Reset (rst_n low) drops any pixel in work and clears the result valid;
//   center is reset to 0 and zoom_shift to 8. Configure over APB only while idle.
module mandelbrot_escape_time_pixel_top #(
    parameter int IMAGE_SIZE = mandel_pkg::IMAGE_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mandel_pix_if.sink                        pixel,
    mandel_grey_if.source                     grey,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mandel_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mandel_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mandel_pkg::CFG_DATA_W-1:0] prdata,
    output logic                              pready
);
    import mandel_pkg::*;

    logic signed [CENTER_W-1:0] center_re;
    logic signed [CENTER_W-1:0] center_im;
    logic [ZOOM_W-1:0]          zoom_shift;
    ctrl_t                      ctrl;
    stat_t                      stat;

    mandel_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .center_re  (center_re),
        .center_im  (center_im),
        .zoom_shift (zoom_shift)
    );

    mandel_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pixel.valid),
        .in_ready   (pixel.ready),
        .out_valid  (grey.valid),
        .out_ready  (grey.ready),
        .grey_level (grey.grey_level),
        .ctrl       (ctrl),
        .stat       (stat)
    );

    mandel_iter #(.IMAGE_SIZE(IMAGE_SIZE)) u_iter (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .pixel_row  (pixel.pixel_row),
        .pixel_col  (pixel.pixel_col),
        .center_re  (center_re),
        .center_im  (center_im),
        .zoom_shift (zoom_shift),
        .stat       (stat)
    );

endmodule

FILE: tb/mandelbrot_escape_time_pixel_top_tb.sv
// Testbench for mandelbrot_escape_time_pixel_top: escape-time grey levels are
// predicted per pixel request and checked in order. Uses mandel_pkg, mandel_ifs.
// Covers register extremes, zoom past the fraction width and backpressure stalls.
module mandelbrot_escape_time_pixel_top_tb;
    import mandel_pkg::*;

    localparam int IMAGE_SIZE  = IMAGE_SIZE_DEF;
    localparam int N_RANDOM    = 1750;
    localparam int MAX_GAP     = 100;
    localparam int LONG_HOLD   = 3000;
    localparam int DRAIN       = 2 * MAX_ITER + 16;
    // slowest pixel plus both sides' longest gap, three times over, plus holds
    localparam int CYCLE_LIMIT = (N_RANDOM + 60) * (2 * MAX_ITER + 8 + 2 * MAX_GAP) * 3
                                 + 4 * LONG_HOLD + 20000;
    localparam int Q_ONE       = 1 << FRAC_BITS;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } pixel_req_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    mandel_pix_if  pix_if();
    mandel_grey_if grey_if();

    mandelbrot_escape_time_pixel_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pix_if),
        .grey    (grey_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Local copy of the view registers
    logic signed [CENTER_W-1:0] view_re;
    logic signed [CENTER_W-1:0] view_im;
    logic [ZOOM_W-1:0]          view_zoom;

    pixel_req_t        pixel_q[$];
    logic [GREY_W-1:0] pending_grey_q[$];
    logic [GREY_W-1:0] want_grey;

    int n_queued;
    int n_accepted;
    int n_checked;
    int n_errors;
    int n_views;
    int n_in_set;
    int n_instant;
    int cycle_count;
    bit pix_taken;
    bit grey_taken;
    int pix_gap;
    int pix_burst;
    int rdy_gap;
    int rdy_burst;
    int hold_left;
    int holds_done;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Point coordinate for one index: center plus scaled offset, clamped under 4
    function automatic longint pixel_coord(longint center, logic [IDX_W-1:0] idx);
        longint d;
        longint off;
        longint c;
        d = longint'(idx) - IMAGE_SIZE / 2;
        // offset magnitude stays far below 2^62 for 9-bit indexes
        if (view_zoom <= FRAC_BITS)
            off = d <<< (FRAC_BITS - view_zoom);
        else
            off = d >>> (view_zoom - FRAC_BITS);
        c = center + off;
        if (c > C_CAP)
            c = C_CAP;
        if (c < -C_CAP)
            c = -C_CAP;
        return c;
    endfunction

    // Escape-time grey level for one pixel under the current view
    function automatic logic [GREY_W-1:0] escape_grey(logic [IDX_W-1:0] row,
                                                      logic [IDX_W-1:0] col);
        longint cr;
        longint ci;
        longint zr;
        longint zi;
        longint ar;
        longint ai;
        longint sr;
        longint si;
        longint prod;
        longint nr;
        int     n;
        bit     escaped;
        cr = pixel_coord(longint'(view_re), col);
        ci = pixel_coord(longint'(view_im), row);
        zr = 0;
        zi = 0;
        n = 0;
        escaped = 1'b0;
        while (n < MAX_ITER && !escaped) begin
            ar = (zr < 0) ? -zr : zr;
            ai = (zi < 0) ? -zi : zi;
            // a component of 2 or more escapes without squaring
            if (ar >= C_TWO || ai >= C_TWO)
                escaped = 1'b1;
            else begin
                sr = ar * ar;
                si = ai * ai;
                if (sr + si >= C_FOUR)
                    escaped = 1'b1;
                else begin
                    // floor back to FRAC_BITS fraction bits, then add c
                    nr = ((sr - si) >>> FRAC_BITS) + cr;
                    prod = longint'(2) * ar * ai;
                    if ((zr < 0) != (zi < 0))
                        prod = -prod;
                    zi = (prod >>> FRAC_BITS) + ci;
                    zr = nr;
                    n++;
                end
            end
        end
        return GREY_W'(MAX_ITER - n);
    endfunction

    // Random idle length: mostly short, a few long, with zero-gap bursts
    function automatic int draw_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, MAX_GAP);
    endfunction

    task automatic report_mismatch(string msg);
        if (n_errors < MAX_PRINTS)
            $display("mismatch @%0d: %s", cycle_count, msg);
        n_errors++;
    endtask

    task automatic queue_pixel(int row, int col);
        pixel_q.push_back('{row: IDX_W'(row), col: IDX_W'(col)});
        n_queued++;
    endtask

    // Two-phase register write; local copy follows at the write edge
    task automatic apb_write(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_CENTER_RE: view_re = data;
            REG_CENTER_IM: view_im = data;
            REG_ZOOM:      view_zoom = data[ZOOM_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_view(int re, int im, int zoom);
        apb_write(REG_CENTER_RE, CFG_DATA_W'(re));
        apb_write(REG_CENTER_IM, CFG_DATA_W'(im));
        // upper bits of the zoom word are don't-care
        apb_write(REG_ZOOM, ($urandom() & ~32'h1F) | CFG_DATA_W'(zoom));
        n_views++;
    endtask

    // Sender holds off until every request has been answered
    task automatic wait_idle();
        while (!(n_accepted == n_queued && pending_grey_q.size() == 0))
            @(negedge clk);
    endtask

    // Request driver
    always @(negedge clk) begin
        if (!rst_n)
            pix_if.valid <= 1'b0;
        else if (pix_taken || !pix_if.valid) begin
            pix_taken = 1'b0;
            if (pix_gap > 0) begin
                pix_gap--;
                pix_if.valid <= 1'b0;
            end
            else if (pixel_q.size() > 0) begin
                pixel_req_t req;
                req = pixel_q.pop_front();
                pix_if.valid     <= 1'b1;
                pix_if.pixel_row <= req.row;
                pix_if.pixel_col <= req.col;
                pix_gap = draw_gap(pix_burst);
            end
            else
                pix_if.valid <= 1'b0;
        end
    end

    // Result sink ready, with two long hold-offs while requests keep coming
    always @(negedge clk) begin
        if (!rst_n)
            grey_if.ready <= 1'b0;
        else begin
            if (grey_taken) begin
                grey_taken = 1'b0;
                rdy_gap = draw_gap(rdy_burst);
            end
            if (holds_done < 2 && n_checked >= (holds_done == 0 ? 60 : 900)) begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                grey_if.ready <= 1'b0;
            end
            else if (rdy_gap > 0) begin
                rdy_gap--;
                grey_if.ready <= 1'b0;
            end
            else
                grey_if.ready <= 1'b1;
        end
    end

    // Monitor: predict on request accept, check on result accept
    always @(posedge clk) begin
        if (rst_n) begin
            if (pix_if.valid && pix_if.ready) begin
                pending_grey_q.push_back(escape_grey(pix_if.pixel_row, pix_if.pixel_col));
                n_accepted++;
                pix_taken = 1'b1;
            end
            if (grey_if.valid && grey_if.ready) begin
                grey_taken = 1'b1;
                if (pending_grey_q.size() == 0)
                    report_mismatch($sformatf("grey_level %0d with no request pending",
                                              grey_if.grey_level));
                else begin
                    want_grey = pending_grey_q.pop_front();
                    if (grey_if.grey_level !== want_grey)
                        report_mismatch($sformatf("result %0d grey_level %0d, predicted %0d",
                                                  n_checked, grey_if.grey_level, want_grey));
                    if (want_grey == 0)
                        n_in_set++;
                    if (want_grey == GREY_W'(MAX_ITER))
                        n_instant++;
                    n_checked++;
                end
            end
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        int total;
        int count;
        int kind;
        int re;
        int im;
        int zoom;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel_row = '0;
        pix_if.pixel_col = '0;
        grey_if.ready = 1'b0;
        view_re = '0;
        view_im = '0;
        view_zoom = ZOOM_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset view: center of the image never escapes, corners and edges
        queue_pixel(256, 256);
        queue_pixel(0, 0);
        queue_pixel(511, 511);
        queue_pixel(0, 511);
        queue_pixel(511, 0);
        queue_pixel(256, 0);
        queue_pixel(0, 256);
        queue_pixel(300, 200);
        wait_idle();

        // Extreme centers at zoom 0: c saturates and escapes after one iteration
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 0);
        queue_pixel(0, 0);
        queue_pixel(511, 511);
        queue_pixel(256, 256);
        wait_idle();
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 0);
        queue_pixel(255, 257);
        queue_pixel(511, 0);
        wait_idle();

        // Zoom beyond the fraction width: offsets round toward minus infinity
        set_view(-3 * Q_ONE / 4, Q_ONE / 10, 31);
        queue_pixel(0, 0);
        queue_pixel(511, 511);
        queue_pixel(257, 255);
        wait_idle();
        // write to an index past the register list is ignored
        apb_write(REG_UNUSED, $urandom());
        apb_write(REG_ZOOM, 29);
        queue_pixel(1, 510);
        queue_pixel(255, 256);
        wait_idle();
        apb_write(REG_ZOOM, 30);
        queue_pixel(510, 1);
        wait_idle();
        // near the boundary at fine spacing: deep iteration counts
        set_view(-199608606, 35379793, 28);
        queue_pixel(0, 511);
        queue_pixel(256, 256);
        wait_idle();

        // Random views, most of them around the set at moderate zoom
        total = 0;
        while (total < N_RANDOM) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                re = $urandom();
                im = $urandom();
                zoom = $urandom_range(0, 31);
            end
            else begin
                re = int'($urandom_range(0, 5 * Q_ONE / 2)) - 2 * Q_ONE;
                im = int'($urandom_range(0, Q_ONE / 10 * 24)) - Q_ONE / 10 * 12;
                zoom = ($urandom_range(0, 99) < 85) ? $urandom_range(5, 20)
                                                    : $urandom_range(0, 31);
            end
            set_view(re, im, zoom);
            count = $urandom_range(40, 100);
            repeat (count)
                queue_pixel($urandom_range(0, 511), $urandom_range(0, 511));
            total += count;
            wait_idle();
        end

        // Drain: nothing further may come out
        repeat (DRAIN) @(posedge clk);
        if (pending_grey_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_grey_q.size()));
        $display("summary: %0d pixels checked across %0d views, %0d errors",
                 n_checked, n_views, n_errors);
        $display("summary: %0d never escaped, %0d escaped before the first iteration",
                 n_in_set, n_instant);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
